>>> rtl/tvtb_pkg.sv
// Shared types, constants and classification functions for the token bucket scheduler.
package tvtb_pkg;

  localparam logic [1:0] OP_ENABLE = 2'd0;
  localparam logic [1:0] OP_ENQ    = 2'd1;
  localparam logic [1:0] OP_RUN    = 2'd2;
  localparam logic [1:0] OP_STOP   = 2'd3;

  localparam logic [2:0] CL_REGULAR = 3'd0;
  localparam logic [2:0] CL_BWTEST  = 3'd1;
  localparam logic [2:0] CL_VDB     = 3'd2;
  localparam logic [2:0] CL_KWORKER = 3'd3;
  localparam logic [2:0] CL_READ    = 3'd4;
  localparam logic [2:0] CL_WRITE   = 3'd5;

  localparam logic [1:0] Q_FALLBACK = 2'd0;
  localparam logic [1:0] Q_READ     = 2'd1;
  localparam logic [1:0] Q_WRITE    = 2'd2;
  localparam logic [1:0] Q_VDB      = 2'd3;

  localparam logic [1:0] DIV_BILLION  = 2'd0;
  localparam logic [1:0] DIV_HUNDRED  = 2'd1;
  localparam logic [1:0] DIV_THOUSAND = 2'd2;

  localparam logic [2:0] REG_SLICE   = 3'd0;
  localparam logic [2:0] REG_RD_RATE = 3'd1;
  localparam logic [2:0] REG_WR_RATE = 3'd2;
  localparam logic [2:0] REG_PAT_ON  = 3'd3;
  localparam logic [2:0] REG_RL_ON   = 3'd4;

  localparam logic [63:0] FULL_BUCKET  = 64'd104857600;
  localparam logic [55:0] BW_THRESHOLD = 56'd73400320;
  localparam logic [63:0] REFILL_NS    = 64'd10000000;
  localparam logic [29:0] NS_PER_SEC   = 30'd1000000000;

  typedef struct packed {
    logic [63:0] vt;
    logic [63:0] tok;
    logic [63:0] refill;
    logic [55:0] rd;
    logic [55:0] wr;
    logic [31:0] loc;
  } entry_t;

  typedef struct packed {
    logic       start;
    logic [1:0] sel;
  } div_req_t;

  function automatic logic [2:0] name_class(input logic [55:0] n);
    logic [31:0] h;
    h = n[31:0];
    if (n == 56'h5f656c62756f64 || h == 32'h646e6162 || h == 32'h746d656d ||
        h == 32'h65727473)
      return CL_BWTEST;
    if (h == 32'h74636576 || h == 32'h73696166 || h == 32'h766c696d ||
        h == 32'h76616577 || h == 32'h68747970)
      return CL_VDB;
    if (n == 56'h72656b726f776b)
      return CL_KWORKER;
    return CL_REGULAR;
  endfunction

  function automatic logic [5:0] class_boost(input logic [2:0] c);
    logic [5:0] b;
    case (c) inside
      CL_BWTEST:          b = 6'd30;
      CL_VDB:             b = 6'd25;
      CL_READ, CL_WRITE:  b = 6'd15;
      CL_KWORKER:         b = 6'd5;
      default:            b = 6'd0;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/tvtb_ram.sv
// Generic single write, single read RAM with registered read data.
module tvtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/tvtb_mul.sv
// Bit-serial shift-add multiplier, 64-bit multiplicand by 16-bit multiplier, mod 2^64.
module tvtb_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a_in,
  input  logic [15:0] b_in,
  output logic        done,
  output logic [63:0] prod
);
  logic [63:0] a;
  logic [15:0] b;
  logic [3:0]  cnt;
  logic        run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a    <= a_in;
        b    <= b_in;
        prod <= '0;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        if (b[0]) begin
          prod <= prod + a;
        end
        a   <= {a[62:0], 1'b0};
        b   <= {1'b0, b[15:1]};
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/tvtb_div.sv
// Restoring bit-serial divider of a 64-bit word by a selected constant, one bit per cycle.
module tvtb_div (
  input  logic                clk,
  input  logic                rst,
  input  tvtb_pkg::div_req_t  req,
  input  logic [63:0]         dividend,
  output logic                done,
  output logic [63:0]         quot
);
  import tvtb_pkg::*;

  logic [29:0] dsr;
  logic [29:0] rem;
  logic [5:0]  cnt;
  logic        run;
  logic [30:0] trial;
  logic        qb;

  assign trial = {rem, quot[63]};
  assign qb    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quot <= dividend;
        rem  <= '0;
        cnt  <= '0;
        run  <= 1'b1;
        case (req.sel)
          DIV_HUNDRED:  dsr <= 30'd100;
          DIV_THOUSAND: dsr <= 30'd1000;
          default:      dsr <= NS_PER_SEC;
        endcase
      end else if (run) begin
        rem  <= qb ? 30'(trial - {1'b0, dsr}) : trial[29:0];
        quot <= {quot[62:0], qb};
        cnt  <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/task_enqueue_vtime_token_bucket_unit.sv
// Top level: virtual time scheduler with per-task token bucket.
//
//  port group        | direction | handshake
//  ------------------+-----------+-------------------------------------------
//  command word      | in        | start high while busy low
//  result word       | out       | done high for one cycle, no back pressure
//  register port     | in/out    | APB write at psel & penable & pwrite
//
// After reset a clearing pass writes TASK_SLOTS table rows, one per cycle, with busy high.
// A running word uses one divide by 1000; enable and stop words use neither unit.
// The multiplier and the divider are both bit-serial; the divider is the slower of the two.
// Enqueue: boost mul and div when admitted, ratio test and refill mul and div when needed.
// An out-of-range enqueue answers the next cycle; other out-of-range words give no result.
// For an enqueue, done rises in the same cycle as busy falls; the receiver cannot stall.
module task_enqueue_vtime_token_bucket_unit #(
  parameter int TASK_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [7:0]  task_slot,
  input  logic [63:0] now,
  input  logic [55:0] name_head,
  input  logic        pattern_valid,
  input  logic [55:0] read_volume,
  input  logic [55:0] write_volume,
  input  logic [31:0] locality,
  output logic        done,
  output logic [1:0]  queue_id,
  output logic [40:0] slice_out,
  output logic [63:0] vtime_out,
  output logic        ordered,
  output logic [2:0]  task_class,
  output logic [5:0]  boost,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import tvtb_pkg::*;

  localparam int AW = $clog2(TASK_SLOTS);
  localparam int CW = (AW > 8) ? AW + 1 : 9;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_RD   = 5'd2;
  localparam logic [4:0] S_RDW  = 5'd3;
  localparam logic [4:0] S_RUN  = 5'd4;
  localparam logic [4:0] S_CLS  = 5'd5;
  localparam logic [4:0] S_M1   = 5'd6;
  localparam logic [4:0] S_M2   = 5'd7;
  localparam logic [4:0] S_M3   = 5'd8;
  localparam logic [4:0] S_BST  = 5'd9;
  localparam logic [4:0] S_RATE = 5'd10;
  localparam logic [4:0] S_FM   = 5'd11;
  localparam logic [4:0] S_FD   = 5'd12;
  localparam logic [4:0] S_VT1  = 5'd13;
  localparam logic [4:0] S_VT2  = 5'd14;
  localparam logic [4:0] S_BM   = 5'd15;
  localparam logic [4:0] S_BD   = 5'd16;
  localparam logic [4:0] S_VT3  = 5'd17;
  localparam logic [4:0] S_WB   = 5'd18;

  logic [39:0] slice_length;
  logic [15:0] read_rate_mb;
  logic [15:0] write_rate_mb;
  logic        pattern_update_on;
  logic        rate_limit_on;

  logic [4:0]    state;
  logic [AW-1:0] ccnt;
  logic [AW-1:0] addr;
  logic [1:0]    op;
  logic [63:0]   now_r;
  logic [55:0]   name_r;
  logic          pv_r;
  logic [55:0]   rd_in;
  logic [55:0]   wr_in;
  logic [31:0]   loc_in;
  entry_t        e;
  entry_t        rdata;
  logic [63:0]   gvt;
  logic [2:0]    cls;
  logic [5:0]    boost_r;
  logic [56:0]   sum;
  logic [63:0]   prd;
  logic          hi;
  logic [63:0]   elapsed;
  logic [63:0]   vt;
  logic [63:0]   gms;
  logic          skip;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;

  logic          mstart;
  logic [63:0]   ma;
  logic [15:0]   mb;
  logic          m_done;
  logic [63:0]   mp;
  div_req_t      dreq;
  logic [63:0]   dvd;
  logic          d_done;
  logic [63:0]   dq;

  logic [63:0]   slice64;
  logic          in_range;
  logic [CW-1:0] slot_ext;
  logic          cfg_wr;
  entry_t        rd_entry;
  logic [2:0]    ncls;

  function automatic logic vt_before(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    return d[63];
  endfunction

  assign slice64  = 64'(slice_length);
  assign slot_ext = CW'(task_slot);
  assign in_range = slot_ext < CW'(TASK_SLOTS);
  assign busy     = state != S_IDLE;
  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign ncls     = name_class(name_r);

  // row as seen by an enqueue, with a fresh pattern merged in when enabled and valid
  always_comb begin
    rd_entry = rdata;
    if (op == OP_ENQ && pattern_update_on && pv_r) begin
      rd_entry.rd  = rd_in;
      rd_entry.wr  = wr_in;
      rd_entry.loc = loc_in;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = e;
    if (state == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = ccnt;
      ram_wdata = '0;
    end else if (state == S_WB) begin
      ram_we = 1'b1;
    end
  end

  tvtb_ram #(.WIDTH($bits(entry_t)), .DEPTH(TASK_SLOTS)) u_table (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(addr), .rdata(rdata)
  );

  tvtb_mul u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a_in(ma), .b_in(mb),
    .done(m_done), .prod(mp)
  );

  tvtb_div u_div (
    .clk(clk), .rst(rst), .req(dreq), .dividend(dvd),
    .done(d_done), .quot(dq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_length      <= 40'd20000000;
      read_rate_mb      <= 16'd1000;
      write_rate_mb     <= 16'd1000;
      pattern_update_on <= 1'b1;
      rate_limit_on     <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_SLICE:   slice_length      <= pwdata[39:0];
        REG_RD_RATE: read_rate_mb      <= pwdata[15:0];
        REG_WR_RATE: write_rate_mb     <= pwdata[15:0];
        REG_PAT_ON:  pattern_update_on <= pwdata[0];
        REG_RL_ON:   rate_limit_on     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_SLICE:   prdata = 64'(slice_length);
      REG_RD_RATE: prdata = 64'(read_rate_mb);
      REG_WR_RATE: prdata = 64'(write_rate_mb);
      REG_PAT_ON:  prdata = 64'(pattern_update_on);
      REG_RL_ON:   prdata = 64'(rate_limit_on);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      ccnt       <= '0;
      done       <= 1'b0;
      mstart     <= 1'b0;
      dreq.start <= 1'b0;
      gvt        <= '0;
    end else begin
      done       <= 1'b0;
      mstart     <= 1'b0;
      dreq.start <= 1'b0;
      unique case (state)
        S_CLR: begin
          ccnt <= ccnt + 1'b1;
          if (ccnt == AW'(TASK_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op     <= operation;
            addr   <= slot_ext[AW-1:0];
            now_r  <= now;
            name_r <= name_head;
            pv_r   <= pattern_valid;
            rd_in  <= read_volume;
            wr_in  <= write_volume;
            loc_in <= locality;
            if (in_range) begin
              state <= S_RD;
            end else if (operation == OP_ENQ) begin
              queue_id   <= Q_FALLBACK;
              slice_out  <= 41'(slice_length);
              vtime_out  <= '0;
              ordered    <= 1'b0;
              task_class <= CL_REGULAR;
              boost      <= '0;
              done       <= 1'b1;
            end
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          e <= rd_entry;
          unique case (op)
            OP_ENABLE: begin
              e.vt     <= gvt;
              e.tok    <= FULL_BUCKET;
              e.refill <= now_r;
              state    <= S_WB;
            end
            OP_RUN: begin
              dvd        <= slice64;
              dreq.sel   <= DIV_THOUSAND;
              dreq.start <= 1'b1;
              state      <= S_RUN;
            end
            OP_STOP: begin
              gvt   <= rdata.vt;
              state <= S_IDLE;
            end
            default: state <= S_CLS;
          endcase
        end
        S_RUN: begin
          if (d_done) begin
            if (e.tok != '0) begin
              e.tok <= (e.tok >= dq) ? e.tok - dq : '0;
            end
            state <= S_WB;
          end
        end
        S_CLS: begin
          sum <= 57'(e.rd) + 57'(e.wr);
          if (ncls != CL_REGULAR) begin
            cls   <= ncls;
            state <= S_BST;
          end else if (e.rd == '0 && e.wr == '0) begin
            cls   <= CL_REGULAR;
            state <= S_BST;
          end else begin
            ma     <= 64'(e.rd);
            mb     <= 16'd100;
            mstart <= 1'b1;
            state  <= S_M1;
          end
        end
        S_M1: begin
          if (m_done) begin
            prd    <= mp;
            ma     <= 64'(sum);
            mb     <= 16'd71;
            mstart <= 1'b1;
            state  <= S_M2;
          end
        end
        S_M2: begin
          if (m_done) begin
            // ratio above 70 means 100*rd >= 71*(rd+wr)
            hi     <= prd >= mp;
            ma     <= 64'(sum);
            mb     <= 16'd30;
            mstart <= 1'b1;
            state  <= S_M3;
          end
        end
        S_M3: begin
          if (m_done) begin
            if (hi && e.rd > BW_THRESHOLD) begin
              cls <= CL_READ;
            end else if (prd < mp && e.wr > BW_THRESHOLD) begin
              cls <= CL_WRITE;
            end else begin
              cls <= CL_REGULAR;
            end
            state <= S_BST;
          end
        end
        S_BST: begin
          boost_r <= class_boost(cls) + ((e.loc > 32'd80) ? 6'd5 : 6'd0);
          elapsed <= now_r - e.refill;
          state   <= S_RATE;
        end
        S_RATE: begin
          if (!rate_limit_on) begin
            state <= S_VT1;
          end else if (elapsed < REFILL_NS) begin
            if (e.tok != '0) begin
              state <= S_VT1;
            end else begin
              // bucket empty: fallback queue, double slice
              queue_id   <= Q_FALLBACK;
              slice_out  <= {slice_length, 1'b0};
              vtime_out  <= '0;
              ordered    <= 1'b0;
              task_class <= cls;
              boost      <= boost_r;
              state      <= S_WB;
            end
          end else begin
            e.refill <= now_r;
            if (cls == CL_READ || cls == CL_WRITE) begin
              ma     <= elapsed;
              mb     <= (cls == CL_READ) ? read_rate_mb : write_rate_mb;
              mstart <= 1'b1;
              state  <= S_FM;
            end else begin
              e.tok <= FULL_BUCKET;
              state <= S_VT1;
            end
          end
        end
        S_FM: begin
          if (m_done) begin
            // times 1 MiB, wrapped at 64 bits
            dvd        <= {mp[43:0], 20'd0};
            dreq.sel   <= DIV_BILLION;
            dreq.start <= 1'b1;
            state      <= S_FD;
          end
        end
        S_FD: begin
          if (d_done) begin
            e.tok <= dq;
            state <= S_VT1;
          end
        end
        S_VT1: begin
          gms <= gvt - slice64;
          if (vt_before(gvt, e.vt)) begin
            vt   <= e.vt;
            skip <= 1'b1;
          end else begin
            vt   <= gvt;
            skip <= 1'b0;
          end
          state <= S_VT2;
        end
        S_VT2: begin
          if (!skip && vt_before(e.vt, gms)) begin
            vt <= gms;
          end
          ma     <= slice64;
          mb     <= 16'(boost_r);
          mstart <= 1'b1;
          state  <= S_BM;
        end
        S_BM: begin
          if (m_done) begin
            dvd        <= mp;
            dreq.sel   <= DIV_HUNDRED;
            dreq.start <= 1'b1;
            state      <= S_BD;
          end
        end
        S_BD: begin
          if (d_done) begin
            vt    <= vt - dq;
            state <= S_VT3;
          end
        end
        S_VT3: begin
          e.vt       <= vt + slice64;
          queue_id   <= (cls == CL_VDB) ? Q_VDB : (cls == CL_READ) ? Q_READ :
                        (cls == CL_WRITE) ? Q_WRITE : Q_FALLBACK;
          slice_out  <= 41'(slice_length);
          vtime_out  <= vt;
          ordered    <= 1'b1;
          task_class <= cls;
          boost      <= boost_r;
          state      <= S_WB;
        end
        S_WB: begin
          done  <= op == OP_ENQ;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result word without a command in flight");

  a_vdb_queue: assert property (@(posedge clk) disable iff (rst)
    (done && ordered && task_class == CL_VDB) |-> queue_id == Q_VDB)
    else $error("vectordb task not routed to its queue");

  a_unordered_key: assert property (@(posedge clk) disable iff (rst)
    (done && !ordered) |-> (vtime_out == '0 && queue_id == Q_FALLBACK))
    else $error("fallback result carries a key or queue");

  a_boost_range: assert property (@(posedge clk) disable iff (rst)
    done |-> boost <= 6'd35)
    else $error("boost out of range");

endmodule

>>> tb/sv/task_enqueue_vtime_token_bucket_unit_test.sv
// Self-checking bench for the virtual time token bucket scheduler.
`timescale 1ns / 1ps

module task_enqueue_vtime_token_bucket_unit_test;
  import tvtb_pkg::*;

  class vtime_sched_scoreboard;
    logic [39:0] slice_len;
    logic [15:0] rd_rate;
    logic [15:0] wr_rate;
    logic        pat_on;
    logic        rl_on;
    logic [63:0] vt_tab [256];
    logic [63:0] tok_tab [256];
    logic [63:0] refill_tab [256];
    logic [55:0] rd_tab [256];
    logic [55:0] wr_tab [256];
    logic [31:0] loc_tab [256];
    logic [63:0] gvt;
    // expected result words: {queue, slice, vtime, ordered, class, boost}
    logic [116:0] pending_results [$];
    int mismatches;
    int results_seen;
    int limited_seen;

    function new();
      slice_len = 40'd20000000;
      rd_rate = 16'd1000;
      wr_rate = 16'd1000;
      pat_on = 1'b1;
      rl_on = 1'b1;
      gvt = '0;
      for (int i = 0; i < 256; i++) begin
        vt_tab[i] = '0; tok_tab[i] = '0; refill_tab[i] = '0;
        rd_tab[i] = '0; wr_tab[i] = '0; loc_tab[i] = '0;
      end
      mismatches = 0;
      results_seen = 0;
      limited_seen = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        REG_SLICE:   slice_len = val[39:0];
        REG_RD_RATE: rd_rate = val[15:0];
        REG_WR_RATE: wr_rate = val[15:0];
        REG_PAT_ON:  pat_on = val[0];
        REG_RL_ON:   rl_on = val[0];
        default: ;
      endcase
    endfunction

    function logic [2:0] prefix_class(logic [55:0] n);
      logic [31:0] h;
      h = n[31:0];
      if (n == {"_", "e", "l", "b", "u", "o", "d"} || h == {"d", "n", "a", "b"} ||
          h == {"t", "m", "e", "m"} || h == {"e", "r", "t", "s"})
        return CL_BWTEST;
      if (h == {"t", "c", "e", "v"} || h == {"s", "i", "a", "f"} ||
          h == {"v", "l", "i", "m"} || h == {"v", "a", "e", "w"} ||
          h == {"h", "t", "y", "p"})
        return CL_VDB;
      if (n == {"r", "e", "k", "r", "o", "w", "k"})
        return CL_KWORKER;
      return CL_REGULAR;
    endfunction

    function void note_word(logic [1:0] op, logic [7:0] slot, logic [63:0] t_now,
                            logic [55:0] name, logic pv, logic [55:0] rb,
                            logic [55:0] wb, logic [31:0] loc);
      logic [63:0] sl, elapsed, fill, vt, ratio, rd, wr, use_amt;
      logic [2:0] cls;
      logic [5:0] bst;
      logic admit;
      logic [1:0] q;
      sl = {24'd0, slice_len};
      case (op)
        OP_ENABLE: begin
          vt_tab[slot] = gvt;
          tok_tab[slot] = FULL_BUCKET;
          refill_tab[slot] = t_now;
        end
        OP_RUN: begin
          use_amt = sl / 1000;
          if (tok_tab[slot] > 0)
            tok_tab[slot] = (tok_tab[slot] >= use_amt) ? tok_tab[slot] - use_amt : 64'd0;
        end
        OP_STOP: gvt = vt_tab[slot];
        default: begin
          if (pat_on && pv) begin
            rd_tab[slot] = rb; wr_tab[slot] = wb; loc_tab[slot] = loc;
          end
          cls = prefix_class(name);
          if (cls == CL_REGULAR) begin
            rd = {8'd0, rd_tab[slot]};
            wr = {8'd0, wr_tab[slot]};
            if (rd != 0 || wr != 0) begin
              ratio = (rd * 100) / (rd + wr);
              if (ratio > 70 && rd > BW_THRESHOLD) cls = CL_READ;
              else if (ratio < 30 && wr > BW_THRESHOLD) cls = CL_WRITE;
            end
          end
          case (cls) inside
            CL_BWTEST: bst = 6'd30;
            CL_VDB: bst = 6'd25;
            CL_READ, CL_WRITE: bst = 6'd15;
            CL_KWORKER: bst = 6'd5;
            default: bst = 6'd0;
          endcase
          if (loc_tab[slot] > 80) bst = bst + 6'd5;
          admit = 1'b1;
          if (rl_on) begin
            elapsed = t_now - refill_tab[slot];
            if (elapsed < REFILL_NS) admit = tok_tab[slot] > 0;
            else begin
              if (cls == CL_READ) fill = ({48'd0, rd_rate} * 64'd1048576 * elapsed) / 1000000000;
              else if (cls == CL_WRITE)
                fill = ({48'd0, wr_rate} * 64'd1048576 * elapsed) / 1000000000;
              else fill = FULL_BUCKET;
              tok_tab[slot] = fill;
              refill_tab[slot] = t_now;
            end
          end
          if (!admit) begin
            limited_seen++;
            pending_results.push_back({Q_FALLBACK, sl[39:0], 1'b0, 64'd0, 1'b0, cls, bst});
          end else begin
            vt = gvt;
            if ((vt - vt_tab[slot]) >> 63) vt = vt_tab[slot];
            else if ((vt_tab[slot] - (vt - sl)) >> 63) vt = vt - sl;
            vt = vt - (sl * bst) / 100;
            vt_tab[slot] = vt + sl;
            q = cls == CL_VDB ? Q_VDB : cls == CL_READ ? Q_READ :
                cls == CL_WRITE ? Q_WRITE : Q_FALLBACK;
            pending_results.push_back({q, 1'b0, sl[39:0], vt, 1'b1, cls, bst});
          end
        end
      endcase
    endfunction

    function void check_word(logic [116:0] got);
      logic [116:0] exp_w;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      exp_w = pending_results.pop_front();
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: q %0d/%0d slice %h/%h vt %h/%h ord %0d/%0d cls %0d/%0d b %0d/%0d",
                   exp_w[116:115], got[116:115], exp_w[114:74], got[114:74],
                   exp_w[73:10], got[73:10], exp_w[9], got[9], exp_w[8:6], got[8:6],
                   exp_w[5:0], got[5:0]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation = '0;
  logic [7:0]  task_slot = '0;
  logic [63:0] now = '0;
  logic [55:0] name_head = '0;
  logic        pattern_valid = 1'b0;
  logic [55:0] read_volume = '0;
  logic [55:0] write_volume = '0;
  logic [31:0] locality = '0;
  logic        done;
  logic [1:0]  queue_id;
  logic [40:0] slice_out;
  logic [63:0] vtime_out;
  logic        ordered;
  logic [2:0]  task_class;
  logic [5:0]  boost;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  localparam int CYCLE_LIMIT = 3000000;

  vtime_sched_scoreboard sched_model;
  int cycle_count = 0;
  int words_sent = 0;
  logic [63:0] clock_ns = 64'd1000;

  task_enqueue_vtime_token_bucket_unit dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout waiting on scheduler");
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && done)
      sched_model.check_word({queue_id, slice_out, vtime_out, ordered, task_class, boost});

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 3'b000}; pwdata <= val; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sched_model.set_reg(idx, val);
  endtask

  task automatic wait_idle();
    while (sched_model.pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_word(logic [1:0] op, logic [7:0] slot, logic [63:0] t_now,
                           logic [55:0] name, logic pv, logic [55:0] rb,
                           logic [55:0] wb, logic [31:0] loc);
    operation <= op; task_slot <= slot; now <= t_now; name_head <= name;
    pattern_valid <= pv; read_volume <= rb; write_volume <= wb; locality <= loc;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sched_model.note_word(op, slot, t_now, name, pv, rb, wb, loc);
    words_sent++;
  endtask

  function automatic logic [55:0] pick_name();
    case ($urandom_range(0, 15))
      0: return {"_", "e", "l", "b", "u", "o", "d"};
      1: return {24'($urandom_range(0, 255)), "d", "n", "a", "b"};
      2: return {24'h414243, "t", "m", "e", "m"};
      3: return {24'h000000, "e", "r", "t", "s"};
      4: return {24'h7a7a7a, "t", "c", "e", "v"};
      5: return {24'h111111, "s", "i", "a", "f"};
      6: return {24'h222222, "v", "l", "i", "m"};
      7: return {24'h333333, "v", "a", "e", "w"};
      8: return {24'h6e6f68, "h", "t", "y", "p"};
      9: return {"r", "e", "k", "r", "o", "w", "k"};
      10: return {"s", "e", "k", "r", "o", "w", "k"};
      default: return 56'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic logic [55:0] pick_bytes();
    case ($urandom_range(0, 4))
      0: return 56'd0;
      1: return 56'hffffffffffffff;
      2: return 56'({$urandom(), $urandom()});
      default: return 56'(($urandom_range(0, 400)) * 64'd1048576 + $urandom_range(0, 1000));
    endcase
  endfunction

  task automatic random_word();
    logic [1:0] op;
    logic [7:0] slot;
    logic [63:0] step;
    int r;
    r = $urandom_range(0, 99);
    op = r < 10 ? OP_ENABLE : r < 65 ? OP_ENQ : r < 85 ? OP_RUN : OP_STOP;
    slot = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0: step = 64'($urandom_range(0, 1000));
      1: step = 64'($urandom_range(9000000, 11000000));
      2: step = 64'($urandom_range(0, 40000000));
      3: step = {$urandom(), $urandom()};
      default: step = 64'($urandom_range(0, 3000000));
    endcase
    clock_ns = clock_ns + step;
    send_word(op, slot, clock_ns, pick_name(), 1'($urandom_range(0, 1)), pick_bytes(),
              pick_bytes(), ($urandom_range(0, 1) ? $urandom() : $urandom_range(70, 90)));
  endtask

  task automatic random_phase(int count);
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst && sent < count; i++) begin
        random_word();
        sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 150)) @(posedge clk);
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    sched_model = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed: enqueue before enable, enable, classes, rate limiting, wrap
    send_word(OP_ENQ, 8'd0, 64'd0, 56'd0, 1'b0, 56'd0, 56'd0, 32'd0);
    send_word(OP_ENABLE, 8'd1, 64'd100, 56'd0, 1'b0, 56'd0, 56'd0, 32'd0);
    send_word(OP_ENQ, 8'd1, 64'd200, {"_", "e", "l", "b", "u", "o", "d"}, 1'b1,
              56'd209715200, 56'd0, 32'd81);
    send_word(OP_ENQ, 8'd1, 64'd300, 56'd0, 1'b1, 56'd209715200, 56'd1000, 32'd80);
    send_word(OP_ENQ, 8'd1, 64'd20000300, 56'd0, 1'b1, 56'd10, 56'd209715200, 32'hffffffff);
    send_word(OP_ENQ, 8'd1, 64'd20000400, {"r", "e", "k", "r", "o", "w", "k"}, 1'b0,
              56'd0, 56'd0, 32'd0);
    send_word(OP_ENQ, 8'd1, 64'd20000500, {24'h0, "t", "c", "e", "v"}, 1'b1,
              56'hffffffffffffff, 56'hffffffffffffff, 32'd0);
    for (int i = 0; i < 6; i++)
      send_word(OP_RUN, 8'd1, 64'd20000600, 56'd0, 1'b0, 56'd0, 56'd0, 32'd0);
    send_word(OP_STOP, 8'd1, 64'd0, 56'd0, 1'b0, 56'd0, 56'd0, 32'd0);
    send_word(OP_ENQ, 8'd1, 64'hffffffffffffffff, 56'd0, 1'b1, 56'd0, 56'd0, 32'd0);
    send_word(OP_ENQ, 8'd255, 64'd5, 56'hffffffffffffff, 1'b1,
              56'hffffffffffffff, 56'hffffffffffffff, 32'hffffffff);
    send_word(OP_ENABLE, 8'd255, 64'hffffffffffffffff, 56'd0, 1'b0, 56'd0, 56'd0, 32'd0);
    send_word(OP_RUN, 8'd255, 64'd0, 56'd0, 1'b0, 56'd0, 56'd0, 32'd0);
    send_word(OP_STOP, 8'd255, 64'd0, 56'd0, 1'b0, 56'd0, 56'd0, 32'd0);
    start <= 1'b0;
    wait_idle();

    // a slice of 1 never drains the bucket; a huge slice drains it at once
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_SLICE, 64'd1);
          write_reg(REG_RD_RATE, 64'd0);
          write_reg(REG_WR_RATE, 64'd65535);
        end
        1: begin
          write_reg(REG_SLICE, 64'hffffffffff);
          write_reg(REG_RD_RATE, 64'd65535);
          write_reg(REG_WR_RATE, 64'd0);
          write_reg(REG_PAT_ON, 64'd0);
        end
        2: begin
          write_reg(REG_SLICE, 64'd400000000);
          write_reg(REG_RL_ON, 64'd0);
          write_reg(REG_PAT_ON, 64'd1);
        end
        3: begin
          write_reg(REG_SLICE, 64'(($urandom() << 8) | $urandom_range(1, 255)));
          write_reg(REG_RD_RATE, 64'($urandom_range(0, 65535)));
          write_reg(REG_WR_RATE, 64'($urandom_range(0, 65535)));
          write_reg(REG_RL_ON, 64'd1);
        end
        4: write_reg(REG_SLICE, 64'd100000000000);
        default: begin
          write_reg(REG_SLICE, 64'd20000000);
          write_reg(REG_RD_RATE, 64'd1000);
          write_reg(REG_WR_RATE, 64'd1000);
        end
      endcase
      random_phase(phase == 5 ? 600 : 200);
      // hold off until the result stream drains
      wait_idle();
    end

    $display("%0d words sent, %0d results checked, %0d rate limited, %0d mismatches",
             words_sent, sched_model.results_seen, sched_model.limited_seen,
             sched_model.mismatches);
    if (sched_model.mismatches == 0 && sched_model.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d results never arrived", sched_model.pending_results.size());
      $display("FAILURE");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/tvtb_pkg.sv
rtl/tvtb_ram.sv
rtl/tvtb_mul.sv
rtl/tvtb_div.sv
rtl/task_enqueue_vtime_token_bucket_unit.sv
tb/sv/task_enqueue_vtime_token_bucket_unit_test.sv
